// ----- src/mrfp_pkg.sv -----
`default_nettype none

package mrfp_pkg;

   localparam int COUNT_WIDTH = 5;
   localparam int PAYLOAD_SIZE = 18;

   localparam logic [COUNT_WIDTH-1:0] PAYLOAD_FIRST = 5'd3;
   localparam logic [COUNT_WIDTH-1:0] PAYLOAD_END = 5'd21;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_GAP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_SHORT = 2'd2
   } status_type;

   typedef struct packed {
      op_type operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [15:0] voltage_raw;
      logic [31:0] current_raw;
      logic [31:0] power_raw;
      logic [31:0] energy_raw;
      logic [15:0] frequency_raw;
      logic [15:0] power_factor_raw;
   } rsp_type;

   // CRC-16/Modbus, reflected, one byte per call
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- src/mrfp_if.sv -----
`default_nettype none

interface mrfp_req_if;
   import mrfp_pkg::*;
   logic valid;
   logic ready;
   logic operation;
   logic [7:0] data_byte;
   modport source(output valid, output operation, output data_byte, input ready);
   modport sink(input valid, input operation, input data_byte, output ready);
endinterface

interface mrfp_rsp_if;
   import mrfp_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [15:0] voltage_raw;
   logic [31:0] current_raw;
   logic [31:0] power_raw;
   logic [31:0] energy_raw;
   logic [15:0] frequency_raw;
   logic [15:0] power_factor_raw;
   modport source(output valid, output status, output voltage_raw, output current_raw,
                  output power_raw, output energy_raw, output frequency_raw,
                  output power_factor_raw, input ready);
   modport sink(input valid, input status, input voltage_raw, input current_raw,
                input power_raw, input energy_raw, input frequency_raw,
                input power_factor_raw, output ready);
endinterface

`default_nettype wire

// ----- src/mrfp_req_reg.sv -----
`default_nettype none

module mrfp_req_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   mrfp_req_if.sink              req_ch,
   input  wire logic             advance,
   output logic                  stage_valid,
   output mrfp_pkg::req_type     stage_req
);
   import mrfp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   logic    accept;

   assign req_ch.ready = !valid_ff || advance;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.operation <= op_type'(req_ch.operation);
         req_ff.data_byte <= req_ch.data_byte;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_req = req_ff;

endmodule

`default_nettype wire

// ----- src/mrfp_parser.sv -----
`default_nettype none

module mrfp_parser #(
   parameter int FRAME_LENGTH = 25
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             stage_valid,
   input  wire mrfp_pkg::req_type stage_req,
   output logic                  advance,
   mrfp_rsp_if.source            rsp_ch
);
   import mrfp_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CRC_LO_IDX = COUNT_WIDTH'(FRAME_LENGTH - 2);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [15:0]            crc_ff, crc_in;
   logic [7:0]             crc_lo_ff;
   logic [7:0]             store_ff [PAYLOAD_SIZE];
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic fire;
   logic emit;
   logic shift;
   logic load_lo;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign fire = stage_valid && advance;

   always_comb begin
      count_in = count_ff;
      crc_in = crc_ff;
      emit = 1'b0;
      shift = 1'b0;
      load_lo = 1'b0;
      rsp_in = '0;
      if (fire) begin
         if (stage_req.operation == OP_GAP) begin
            if (count_ff != '0) begin
               emit = 1'b1;
               rsp_in.status = STATUS_SHORT;
               count_in = '0;
               crc_in = CRC_INIT;
            end
         end else if (count_ff < CRC_LO_IDX) begin
            crc_in = crc_byte(crc_ff, stage_req.data_byte);
            shift = (count_ff >= PAYLOAD_FIRST) && (count_ff < PAYLOAD_END);
            count_in = count_ff + 1'b1;
         end else if (count_ff == CRC_LO_IDX) begin
            load_lo = 1'b1;
            count_in = count_ff + 1'b1;
         end else begin
            // last byte carries the CRC high byte
            emit = 1'b1;
            count_in = '0;
            crc_in = CRC_INIT;
            if ({stage_req.data_byte, crc_lo_ff} == crc_ff) begin
               rsp_in.status = STATUS_OK;
               rsp_in.voltage_raw = {store_ff[0], store_ff[1]};
               rsp_in.current_raw = {store_ff[4], store_ff[5], store_ff[2], store_ff[3]};
               rsp_in.power_raw = {store_ff[8], store_ff[9], store_ff[6], store_ff[7]};
               rsp_in.energy_raw = {store_ff[12], store_ff[13], store_ff[10], store_ff[11]};
               rsp_in.frequency_raw = {store_ff[14], store_ff[15]};
               rsp_in.power_factor_raw = {store_ff[16], store_ff[17]};
            end else begin
               rsp_in.status = STATUS_CRC_ERR;
            end
         end
      end
   end

   always_comb begin
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         crc_ff <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload bytes shift in; after a full frame entry k holds frame byte k+3
   always_ff @(posedge clock) begin
      if (shift) begin
         for (int i = 0; i < PAYLOAD_SIZE - 1; i++) begin
            store_ff[i] <= store_ff[i+1];
         end
         store_ff[PAYLOAD_SIZE-1] <= stage_req.data_byte;
      end
      if (load_lo) begin
         crc_lo_ff <= stage_req.data_byte;
      end
      if (fire && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_ff.status;
   assign rsp_ch.voltage_raw = rsp_ff.voltage_raw;
   assign rsp_ch.current_raw = rsp_ff.current_raw;
   assign rsp_ch.power_raw = rsp_ff.power_raw;
   assign rsp_ch.energy_raw = rsp_ff.energy_raw;
   assign rsp_ch.frequency_raw = rsp_ff.frequency_raw;
   assign rsp_ch.power_factor_raw = rsp_ff.power_factor_raw;

endmodule

`default_nettype wire

// ----- src/meter_response_frame_parser.sv -----
// A result is valid once the request that ends the frame has passed the input
// register, then the frame state and result register.
// Throughput: one request per cycle unless the result side stalls; the
// per-byte CRC update and payload shift are done between the two registers.
// Reset (synchronous, active high) clears valid bits, byte count and CRC to
// 0xFFFF; payload bytes and the CRC low byte are loaded before use.
`default_nettype none

module meter_response_frame_parser #(
   parameter int FRAME_LENGTH = 25
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mrfp_req_if.sink   req_ch,
   mrfp_rsp_if.source rsp_ch
);
   import mrfp_pkg::*;

   logic    stage_valid;
   req_type stage_req;
   logic    advance;

   mrfp_req_reg u_req_reg (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_req   (stage_req)
   );

   mrfp_parser #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_req   (stage_req),
      .advance     (advance),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- sim/tb_meter_response_frame_parser.sv -----
import mrfp_pkg::*;

class meter_reply_scoreboard;
   int frame_len;
   logic [4:0] byte_count;
   logic [15:0] crc_acc;
   logic [7:0] payload [PAYLOAD_SIZE];
   logic [7:0] crc_low;
   rsp_type pending_replies[$];
   int mismatches;

   function new(int len);
      frame_len = len;
      mismatches = 0;
      crc_low = 8'h00;
      foreach (payload[i]) payload[i] = 8'h00;
      restart_frame();
   endfunction

   // bit-serial CRC-16/Modbus, LSB of the data first
   static function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      logic feedback;
      int k;
      c = crc;
      for (k = 0; k < 8; k++) begin
         feedback = c[0] ^ data[k];
         c = c >> 1;
         if (feedback) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function void restart_frame();
      byte_count = '0;
      crc_acc = CRC_INIT;
   endfunction

   // 32-bit meter value starting at frame byte 'first': low word on the wire first
   function logic [31:0] swapped_word(int first);
      return {payload[first-1], payload[first], payload[first-3], payload[first-2]};
   endfunction

   function void note_request(req_type r);
      rsp_type reply;
      reply = '0;
      if (r.operation == OP_GAP) begin
         if (byte_count != 0) begin
            reply.status = STATUS_SHORT;
            pending_replies.push_back(reply);
            restart_frame();
         end
      end else if (byte_count < frame_len - 2) begin
         crc_acc = crc_next(crc_acc, r.data_byte);
         if (byte_count >= PAYLOAD_FIRST && byte_count < PAYLOAD_END)
            payload[byte_count - PAYLOAD_FIRST] = r.data_byte;
         byte_count++;
      end else if (byte_count == frame_len - 2) begin
         crc_low = r.data_byte;
         byte_count++;
      end else begin
         if ({r.data_byte, crc_low} == crc_acc) begin
            reply.status = STATUS_OK;
            reply.voltage_raw = {payload[0], payload[1]};
            reply.current_raw = swapped_word(5);
            reply.power_raw = swapped_word(9);
            reply.energy_raw = swapped_word(13);
            reply.frequency_raw = {payload[14], payload[15]};
            reply.power_factor_raw = {payload[16], payload[17]};
         end else begin
            reply.status = STATUS_CRC_ERR;
         end
         pending_replies.push_back(reply);
         restart_frame();
      end
   endfunction

   task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task check_reply(rsp_type got);
      rsp_type want;
      if (pending_replies.size() == 0) begin
         report($sformatf("reply with none pending, status %0d", got.status));
         return;
      end
      want = pending_replies.pop_front();
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("voltage_raw", 32'(got.voltage_raw), 32'(want.voltage_raw));
      compare_field("current_raw", got.current_raw, want.current_raw);
      compare_field("power_raw", got.power_raw, want.power_raw);
      compare_field("energy_raw", got.energy_raw, want.energy_raw);
      compare_field("frequency_raw", 32'(got.frequency_raw), 32'(want.frequency_raw));
      compare_field("power_factor_raw", 32'(got.power_factor_raw),
                    32'(want.power_factor_raw));
   endtask
endclass

module tb_meter_response_frame_parser;

   localparam int FRAME_LEN = 25;
   localparam int TARGET_REQUESTS = 1750;
   localparam int HOLD_AT_REQUEST = 700;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset;

   mrfp_req_if req_ch();
   mrfp_rsp_if rsp_ch();

   meter_response_frame_parser #(.FRAME_LENGTH(FRAME_LEN)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   meter_reply_scoreboard replies;
   logic [7:0] frame_buf [FRAME_LEN-2];
   int requests_sent = 0;
   int sender_gap_pct = 0;
   int idle_cycles = 0;
   bit long_hold_due = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // no gap unless a draw falls under pct; when there is one, usually short, now and then long
   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   task automatic send_request(op_type op, logic [7:0] data);
      int gap;
      gap = pick_gap(sender_gap_pct);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.data_byte <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      requests_sent++;
   endtask

   // mode 0: random reply body, 1: all zero, 2: all ones, 3: alternating
   function automatic void fill_frame(int mode);
      int i;
      for (i = 0; i < FRAME_LEN - 2; i++) begin
         case (mode)
            0: frame_buf[i] = 8'($urandom_range(255));
            1: frame_buf[i] = 8'h00;
            2: frame_buf[i] = 8'hFF;
            default: frame_buf[i] = (i % 2) ? 8'hFF : 8'h00;
         endcase
      end
      if (mode == 0 && $urandom_range(1)) begin
         frame_buf[1] = 8'h04;
         frame_buf[2] = 8'h14;
      end
   endfunction

   task automatic send_frame(bit corrupt);
      logic [15:0] crc;
      int i;
      crc = CRC_INIT;
      for (i = 0; i < FRAME_LEN - 2; i++)
         crc = replies.crc_next(crc, frame_buf[i]);
      if (corrupt) begin
         if ($urandom_range(1))
            crc = crc ^ (16'h0001 << $urandom_range(15));
         else
            frame_buf[$urandom_range(FRAME_LEN - 3)] ^= (8'h01 << $urandom_range(7));
      end
      for (i = 0; i < FRAME_LEN - 2; i++) send_request(OP_BYTE, frame_buf[i]);
      send_request(OP_BYTE, crc[7:0]);
      send_request(OP_BYTE, crc[15:8]);
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      req_type taken;
      if (!reset) begin
         // check first: a reply at this edge belongs to an earlier request
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = status_type'(rsp_ch.status);
            got.voltage_raw = rsp_ch.voltage_raw;
            got.current_raw = rsp_ch.current_raw;
            got.power_raw = rsp_ch.power_raw;
            got.energy_raw = rsp_ch.energy_raw;
            got.frequency_raw = rsp_ch.frequency_raw;
            got.power_factor_raw = rsp_ch.power_factor_raw;
            replies.check_reply(got);
         end
         if (req_ch.valid && req_ch.ready) begin
            taken.operation = op_type'(req_ch.operation);
            taken.data_byte = req_ch.data_byte;
            replies.note_request(taken);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : reply_sink
      int stall_left;
      int stall_pct;
      int phase_left;
      stall_left = 0;
      stall_pct = 0;
      phase_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            phase_left = 150;
            case ($urandom_range(3))
               0: stall_pct = 0;
               1: stall_pct = 10;
               2: stall_pct = 30;
               default: stall_pct = 60;
            endcase
         end
         phase_left--;
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap(stall_pct);
         end
      end
   end

   initial begin : stimulus
      int kind;
      int len;
      bit hold_done;
      hold_done = 1'b0;
      replies = new(FRAME_LEN);
      req_ch.valid <= 1'b0;
      req_ch.operation <= OP_BYTE;
      req_ch.data_byte <= 8'h00;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // gap on an idle line, a one-byte short frame, then a clean frame of extremes
      send_request(OP_GAP, 8'hFF);
      send_request(OP_BYTE, 8'hFF);
      send_request(OP_GAP, 8'h00);
      fill_frame(3);
      send_frame(1'b0);

      while (requests_sent < TARGET_REQUESTS) begin
         case ($urandom_range(4))
            0, 1: sender_gap_pct = 0;
            2: sender_gap_pct = 10;
            3: sender_gap_pct = 30;
            default: sender_gap_pct = 60;
         endcase
         if (!hold_done && requests_sent >= HOLD_AT_REQUEST) begin
            // back-to-back short frames while the reply side holds off
            hold_done = 1'b1;
            long_hold_due = 1'b1;
            sender_gap_pct = 0;
            repeat (40) begin
               send_request(OP_BYTE, 8'($urandom_range(255)));
               send_request(OP_GAP, 8'($urandom_range(255)));
            end
         end
         kind = $urandom_range(99);
         if (kind < 65) begin
            fill_frame(($urandom_range(9) < 7) ? 0 : $urandom_range(3, 1));
            send_frame(1'b0);
         end else if (kind < 78) begin
            fill_frame(($urandom_range(9) < 7) ? 0 : $urandom_range(3, 1));
            send_frame(1'b1);
         end else if (kind < 90) begin
            len = $urandom_range(FRAME_LEN - 1, 1);
            repeat (len) send_request(OP_BYTE, 8'($urandom_range(255)));
            send_request(OP_GAP, 8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(8, 1))
               send_request(op_type'($urandom_range(1)), 8'($urandom_range(255)));
            // resync to a frame boundary
            send_request(OP_GAP, 8'($urandom_range(255)));
         end
      end
      req_ch.valid <= 1'b0;

      // let the monitor note the last request before looking at the queue
      @(posedge clock);
      while (replies.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (replies.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
src/mrfp_pkg.sv
src/mrfp_if.sv
src/mrfp_req_reg.sv
src/mrfp_parser.sv
src/meter_response_frame_parser.sv
sim/tb_meter_response_frame_parser.sv
